FILE: design/fdct_pkg.sv
// shared types, constants and the 8-point transform function for the forward dct
package fdct_pkg;

  localparam int unsigned C1 = 1420;
  localparam int unsigned C2 = 1338;
  localparam int unsigned C3 = 1204;
  localparam int unsigned C5 = 805;
  localparam int unsigned C6 = 554;
  localparam int unsigned C7 = 283;
  localparam int unsigned ROW_SHIFT = 10;
  localparam int unsigned COL_SHIFT = 13;
  localparam int unsigned DC_SHIFT = 3;

  typedef logic signed [15:0] word_t;
  typedef word_t vec8_t [8];

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_OUT
  } state_t;

  // multiply a sign-extended difference by a small positive constant
  function automatic logic signed [31:0] mulc(logic signed [16:0] d, int unsigned c);
    logic signed [31:0] cc;
    cc = 32'(c);
    return 32'(d) * cc;
  endfunction

  // one 8-point pass, each output wrapped to 16 bits
  function automatic vec8_t pass8(vec8_t v, logic col);
    logic signed [16:0] s07, d07, s16, d16, s25, d25, s34, d34;
    logic signed [17:0] e0, e1, e2, e3;
    logic signed [31:0] r0, r4, r2, r6, r7, r5, r3, r1;
    logic signed [31:0] e1x, e3x;
    vec8_t r;
    int unsigned es, os;
    es = col ? DC_SHIFT : 0;
    os = col ? COL_SHIFT : ROW_SHIFT;
    s07 = 17'(v[0]) + 17'(v[7]); d07 = 17'(v[0]) - 17'(v[7]);
    s16 = 17'(v[1]) + 17'(v[6]); d16 = 17'(v[1]) - 17'(v[6]);
    s25 = 17'(v[2]) + 17'(v[5]); d25 = 17'(v[2]) - 17'(v[5]);
    s34 = 17'(v[3]) + 17'(v[4]); d34 = 17'(v[3]) - 17'(v[4]);
    e0 = 18'(s07) + 18'(s34); e1 = 18'(s07) - 18'(s34);
    e2 = 18'(s16) + 18'(s25); e3 = 18'(s16) - 18'(s25);
    e1x = 32'(e1);
    e3x = 32'(e3);
    r0 = (32'(e0) + 32'(e2)) >>> es;
    r4 = (32'(e0) - 32'(e2)) >>> es;
    r2 = (e1x * 32'sd1338 + e3x * 32'sd554) >>> os;
    r6 = (e1x * 32'sd554 - e3x * 32'sd1338) >>> os;
    r7 = (mulc(d07, C7) - mulc(d16, C5) + mulc(d25, C3) - mulc(d34, C1)) >>> os;
    r5 = (mulc(d07, C5) - mulc(d16, C1) + mulc(d25, C7) + mulc(d34, C3)) >>> os;
    r3 = (mulc(d07, C3) - mulc(d16, C7) - mulc(d25, C1) - mulc(d34, C5)) >>> os;
    r1 = (mulc(d07, C1) + mulc(d16, C3) + mulc(d25, C5) + mulc(d34, C7)) >>> os;
    r[0] = r0[15:0]; r[1] = r1[15:0]; r[2] = r2[15:0]; r[3] = r3[15:0];
    r[4] = r4[15:0]; r[5] = r5[15:0]; r[6] = r6[15:0]; r[7] = r7[15:0];
    return r;
  endfunction

endpackage

FILE: design/fdct_ram.sv
// 64 x 16 block store with one write port and one registered read port
module fdct_ram
  import fdct_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [5:0] waddr,
  input  word_t      wdata,
  input  logic [5:0] raddr,
  output word_t      rdata
);

  word_t mem [64];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/forward_dct_8x8_top.sv
// top level: sample loading, row and column passes over the store, coefficient output
// after the 64th sample is taken, 16 passes (8 row, 8 column) run before the first coefficient is read
// one sample per cycle while loading; a new coefficient read starts only once the output register is free
// each pass reads 8 words through the single read port, computes, then writes 8 back
// a block loads only after the last coefficient of the block before it is taken
// reset: synchronous rst clears the sequencer and counters; store contents stay undefined
module forward_dct_8x8_top
  import fdct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  output logic  ready_in,
  input  word_t sample,
  output logic  valid_out,
  input  logic  ready_out,
  output word_t coefficient,
  output logic  last
);

  state_t state, state_next;
  logic [5:0] count;     // load address or output address
  logic [3:0] pass;      // 0..7 rows, 8..15 columns
  logic [3:0] step;      // element step within a pass
  logic       rd_pend;   // output read in flight
  vec8_t      buf8, res8;
  logic       we;
  logic [5:0] waddr, raddr;
  word_t      wdata, rdata;
  logic [5:0] elem_addr;
  logic [5:0] out_addr;

  fdct_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // address of element step within current pass
  always_comb begin
    if (pass[3]) begin
      elem_addr = {step[2:0], pass[2:0]};
    end else begin
      elem_addr = {pass[2:0], step[2:0]};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (valid_in && count == 6'd63) state_next = ST_READ;
      ST_READ:  if (step == 4'd8) state_next = ST_CALC;
      ST_CALC:  state_next = ST_WRITE;
      ST_WRITE: if (step == 4'd7) state_next = (pass == 4'd15) ? ST_OUT : ST_READ;
      ST_OUT:   if (valid_out && ready_out && last) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  assign out_addr = count;

  // outputs and memory control
  always_comb begin
    ready_in = (state == ST_LOAD);
    we = 1'b0;
    waddr = elem_addr;
    wdata = res8[step[2:0]];
    raddr = elem_addr;
    unique case (state)
      ST_LOAD: begin
        we = valid_in;
        waddr = count;
        wdata = sample;
      end
      ST_WRITE: we = 1'b1;
      ST_OUT: raddr = out_addr;
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      pass <= '0;
      step <= '0;
      rd_pend <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: if (valid_in) count <= count + 6'd1;
        ST_READ: step <= (step == 4'd8) ? 4'd0 : step + 4'd1;
        ST_CALC: step <= 4'd0;
        ST_WRITE: begin
          step <= (step == 4'd7) ? 4'd0 : step + 4'd1;
          if (step == 4'd7) pass <= pass + 4'd1;
        end
        ST_OUT: begin
          // one read in flight; output register holds until taken
          if (valid_out && ready_out) valid_out <= 1'b0;
          if (rd_pend) begin
            valid_out <= 1'b1;
            rd_pend <= 1'b0;
            count <= count + 6'd1;
          end else if (!valid_out || ready_out) begin
            if (!(valid_out && last)) rd_pend <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // pass data and output payload
  always_ff @(posedge clk) begin
    if (state == ST_READ && step != 4'd0) begin
      buf8[step[2:0] - 3'd1] <= rdata;
    end
    if (state == ST_CALC) begin
      res8 <= pass8(buf8, pass[3]);
    end
    if (state == ST_OUT && rd_pend) begin
      coefficient <= rdata;
      last <= (count == 6'd63);
    end
  end

endmodule
